// ===== rtl/lspb_pkg.sv =====
// lspb_pkg: shared types and constants for the last significant position binarizer
// holds the beat structs and the controller/datapath command and status groups
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lspb_pkg;

   // chroma context set starts here in the axis context table
   localparam logic [4:0] CHROMA_CTX_BASE = 5'd15;
   // coordinates below this have a prefix equal to themselves and no suffix
   localparam logic [4:0] PREFIX_ONLY_LIMIT = 5'd4;

   typedef struct packed {
      logic [4:0] pos_x;
      logic [4:0] pos_y;
      logic [2:0] log2_size;
      logic       is_chroma;
   } req_type;

   typedef struct packed {
      logic       bin_value;
      logic [4:0] ctx_index;
      logic       axis;
      logic       bypass;
      logic       last_bin;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_PRE_X,
      PH_PRE_Y,
      PH_SUF_X,
      PH_SUF_Y
   } phase_type;

   typedef struct packed {
      logic      load;
      logic      emit;
      phase_type phase;
      logic      last;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic phase_end;
      logic sfx_x_none;
      logic sfx_y_none;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/last_sig_position_binarizer.sv =====
// last_sig_position_binarizer: one input beat yields 2 to 24 bin beats, one per cycle while rsp is not stalled
// first bin: the req beat is loaded, the sequencer enters prefix x and the bin is registered on rsp
// positions: a new req beat is taken only once the sequencer is idle again; the single
// bin counter walks prefix x, prefix y, suffix x, suffix y; rsp stall holds the bin flow
// reset: synchronous, active high; clears the sequencer and the rsp valid flag
`timescale 1ns / 1ps
`default_nettype none

module last_sig_position_binarizer #(
   parameter int MAX_LOG2_SIZE = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // position beat in
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lspb_pkg::req_type req_data,
   // bin beat out
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lspb_pkg::rsp_type      rsp_data
);

   // command and status between the sequencer and the datapath
   lspb_pkg::cmd_type cmd;
   lspb_pkg::sts_type sts;

   // sequencer: takes a beat only when idle, then steps through the four phases,
   // skipping a suffix phase that has no bits and flagging the final bin
   lspb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: clamps size and positions, splits each coordinate into prefix and
   // suffix, builds context indexes and holds the bin in the output register
   lspb_datapath #(
      .MAX_LOG2_SIZE (MAX_LOG2_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/lspb_datapath.sv =====
// lspb_datapath: position split, context offsets, bin counter and output register
// driven by lspb_ctrl through lspb_pkg::cmd_type, reports lspb_pkg::sts_type
// depends on lspb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lspb_datapath #(
   parameter int MAX_LOG2_SIZE = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lspb_pkg::req_type req_data,
   input  wire logic             rsp_stall,
   input  wire lspb_pkg::cmd_type cmd,
   output lspb_pkg::sts_type     sts,
   output logic                  rsp_valid,
   output lspb_pkg::rsp_type     rsp_data
);

   localparam logic [2:0] MAX_LG = 3'(MAX_LOG2_SIZE);

   typedef struct packed {
      logic [3:0] prefix;
      logic [2:0] suffix;
      logic [1:0] nbits;
   } split_type;

   function automatic split_type split_pos(input logic [4:0] p);
      split_type s;
      s = '0;
      if (p < lspb_pkg::PREFIX_ONLY_LIMIT) begin
         s.prefix = p[3:0];
      end else if (p[4]) begin
         s.prefix = 4'd8 + {3'd0, p[3]};
         s.nbits  = 2'd3;
         s.suffix = p[2:0];
      end else if (p[3]) begin
         s.prefix = 4'd6 + {3'd0, p[2]};
         s.nbits  = 2'd2;
         s.suffix = {1'b0, p[1:0]};
      end else begin
         s.prefix = 4'd4 + {3'd0, p[1]};
         s.nbits  = 2'd1;
         s.suffix = {2'b00, p[0]};
      end
      return s;
   endfunction

   logic [2:0] lg;
   logic [5:0] lim_wide;
   logic [4:0] lim;
   logic [4:0] px;
   logic [4:0] py;
   logic [4:0] lg_m2;
   logic [4:0] off_in;
   logic [1:0] sh_in;
   split_type  split_x;
   split_type  split_y;

   split_type         split_x_ff, split_x_in;
   split_type         split_y_ff, split_y_in;
   logic [4:0]        ctx_off_ff, ctx_off_in;
   logic [1:0]        ctx_sh_ff, ctx_sh_in;
   logic [3:0]        cmax_ff, cmax_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lspb_pkg::rsp_type rsp_ff, rsp_in;

   logic [3:0] cur_prefix;
   logic [2:0] cur_suffix;
   logic [1:0] cur_nbits;
   logic [3:0] cnt_sh;
   logic [1:0] sfx_idx;
   logic       bin_val;
   logic [4:0] bin_ctx;
   logic       phase_end;
   logic       slot_free;

   // size clamp, position clamp and split of the incoming beat
   always_comb begin
      if (req_data.log2_size < 3'd2) begin
         lg = 3'd2;
      end else if (req_data.log2_size > MAX_LG) begin
         lg = MAX_LG;
      end else begin
         lg = req_data.log2_size;
      end
      lim_wide = (6'd1 << lg) - 6'd1;
      lim      = lim_wide[4:0];
      px       = (req_data.pos_x > lim) ? lim : req_data.pos_x;
      py       = (req_data.pos_y > lim) ? lim : req_data.pos_y;
      split_x  = split_pos(px);
      split_y  = split_pos(py);
      lg_m2    = {2'b00, lg - 3'd2};
      if (req_data.is_chroma) begin
         off_in = lspb_pkg::CHROMA_CTX_BASE;
         sh_in  = 2'(lg - 3'd2);
      end else begin
         off_in = (lg_m2 << 1) + lg_m2 + {2'b00, (lg - 3'd1) >> 2};
         sh_in  = 2'((lg + 3'd1) >> 2);
      end
   end

   // current bin for the phase the controller selects
   always_comb begin
      case (cmd.phase)
         lspb_pkg::PH_PRE_X: begin
            cur_prefix = split_x_ff.prefix;
            cur_suffix = split_x_ff.suffix;
            cur_nbits  = split_x_ff.nbits;
         end
         lspb_pkg::PH_PRE_Y: begin
            cur_prefix = split_y_ff.prefix;
            cur_suffix = split_y_ff.suffix;
            cur_nbits  = split_y_ff.nbits;
         end
         lspb_pkg::PH_SUF_X: begin
            cur_prefix = split_x_ff.prefix;
            cur_suffix = split_x_ff.suffix;
            cur_nbits  = split_x_ff.nbits;
         end
         default: begin
            cur_prefix = split_y_ff.prefix;
            cur_suffix = split_y_ff.suffix;
            cur_nbits  = split_y_ff.nbits;
         end
      endcase
      cnt_sh  = cnt_ff >> ctx_sh_ff;
      sfx_idx = 2'(cur_nbits - 2'd1 - cnt_ff[1:0]);
      if (cmd.phase == lspb_pkg::PH_PRE_X || cmd.phase == lspb_pkg::PH_PRE_Y) begin
         bin_val   = cnt_ff < cur_prefix;
         bin_ctx   = ctx_off_ff + {1'b0, cnt_sh};
         phase_end = (cur_prefix == cmax_ff) ? (cnt_ff + 4'd1 == cur_prefix)
                                             : (cnt_ff == cur_prefix);
      end else begin
         bin_val   = cur_suffix[sfx_idx];
         bin_ctx   = '0;
         phase_end = cnt_ff == {2'b00, cur_nbits - 2'd1};
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign sts       = '{slot_free:  slot_free,
                        phase_end:  phase_end,
                        sfx_x_none: split_x_ff.nbits == 2'd0,
                        sfx_y_none: split_y_ff.nbits == 2'd0};

   always_comb begin
      split_x_in   = split_x_ff;
      split_y_in   = split_y_ff;
      ctx_off_in   = ctx_off_ff;
      ctx_sh_in    = ctx_sh_ff;
      cmax_in      = cmax_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         split_x_in = split_x;
         split_y_in = split_y;
         ctx_off_in = off_in;
         ctx_sh_in  = sh_in;
         cmax_in    = {lg, 1'b0} - 4'd1;
         cnt_in     = '0;
      end
      if (cmd.emit) begin
         rsp_valid_in     = 1'b1;
         rsp_in.bin_value = bin_val;
         rsp_in.ctx_index = bin_ctx;
         rsp_in.axis      = cmd.phase == lspb_pkg::PH_PRE_Y
                         || cmd.phase == lspb_pkg::PH_SUF_Y;
         rsp_in.bypass    = cmd.phase == lspb_pkg::PH_SUF_X
                         || cmd.phase == lspb_pkg::PH_SUF_Y;
         rsp_in.last_bin  = cmd.last;
         cnt_in           = phase_end ? 4'd0 : cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      split_x_ff <= split_x_in;
      split_y_ff <= split_y_in;
      ctx_off_ff <= ctx_off_in;
      ctx_sh_ff  <= ctx_sh_in;
      cmax_ff    <= cmax_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/lspb_ctrl.sv =====
// lspb_ctrl: sequencer over the prefix and suffix phases of one position
// issues lspb_pkg::cmd_type to lspb_datapath and reads lspb_pkg::sts_type back
// depends on lspb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lspb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lspb_pkg::sts_type sts,
   output lspb_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE_X,
      ST_PRE_Y,
      ST_SUF_X,
      ST_SUF_Y
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.emit  = 1'b0;
      cmd.phase = lspb_pkg::PH_PRE_X;
      cmd.last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_PRE_X;
            end
         end
         ST_PRE_X: begin
            cmd.emit  = sts.slot_free;
            cmd.phase = lspb_pkg::PH_PRE_X;
            if (sts.slot_free && sts.phase_end) begin
               state_in = ST_PRE_Y;
            end
         end
         ST_PRE_Y: begin
            cmd.emit  = sts.slot_free;
            cmd.phase = lspb_pkg::PH_PRE_Y;
            cmd.last  = sts.phase_end && sts.sfx_x_none && sts.sfx_y_none;
            if (sts.slot_free && sts.phase_end) begin
               if (!sts.sfx_x_none) begin
                  state_in = ST_SUF_X;
               end else if (!sts.sfx_y_none) begin
                  state_in = ST_SUF_Y;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SUF_X: begin
            cmd.emit  = sts.slot_free;
            cmd.phase = lspb_pkg::PH_SUF_X;
            cmd.last  = sts.phase_end && sts.sfx_y_none;
            if (sts.slot_free && sts.phase_end) begin
               state_in = sts.sfx_y_none ? ST_IDLE : ST_SUF_Y;
            end
         end
         ST_SUF_Y: begin
            cmd.emit  = sts.slot_free;
            cmd.phase = lspb_pkg::PH_SUF_Y;
            cmd.last  = sts.phase_end;
            if (sts.slot_free && sts.phase_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

`default_nettype wire
